FILE: design/cid_pkg.sv
`default_nettype none

package cid_pkg;

  localparam int unsigned IdW  = 8;
  localparam int unsigned ChW  = 16;
  localparam int unsigned AnsW = 17;
  localparam int unsigned SzW  = 9;
  localparam int unsigned CmpW = 13;

  localparam logic OP_QUERY  = 1'b0;
  localparam logic OP_INSERT = 1'b1;

  localparam logic ST_OK  = 1'b0;
  localparam logic ST_BAD = 1'b1;

  localparam logic [ChW-1:0] CH_MAX = '1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DONE
  } cid_state_e;

  // broadcast from the controller to every cell
  typedef struct packed {
    logic           upd;
    logic [IdW-1:0] idx;
    logic [ChW-1:0] id;
    logic [SzW-1:0] size;
    logic [IdW-1:0] target;
  } cid_bcast_t;

endpackage

`default_nettype wire

FILE: design/cid_cell.sv
`default_nettype none

module cid_cell
  import cid_pkg::*;
#(
  parameter int unsigned POS = 0
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire cid_bcast_t     bc_i,
  input  wire logic [ChW-1:0] car_i,
  output      logic [ChW-1:0] car_o
);

  localparam logic [CmpW-1:0] PosC = CmpW'(POS);

  logic [ChW-1:0] entry_q, entry_d;
  logic [ChW-1:0] car_q, car_d;
  logic           at_idx, above_idx, in_size, left_of_target;

  always_comb begin
    at_idx         = PosC == CmpW'(bc_i.idx);
    above_idx      = PosC >  CmpW'(bc_i.idx);
    in_size        = PosC <  CmpW'(bc_i.size);
    left_of_target = PosC <  CmpW'(bc_i.target);

    entry_d = entry_q;
    if (bc_i.upd) begin
      if (at_idx) begin
        entry_d = bc_i.id;
      end else if (above_idx && in_size && entry_q != '0 && entry_q != CH_MAX) begin
        entry_d = entry_q + ChW'(1);
      end
    end

    // nearest non-zero entry to the left of the target
    car_d = (left_of_target && entry_q != '0) ? entry_q : car_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_q <= '0;
    end else begin
      entry_q <= entry_d;
    end
  end

  always_ff @(posedge clk_i) begin
    car_q <= car_d;
  end

  assign car_o = car_q;

endmodule

`default_nettype wire

FILE: design/chunk_id_directory.sv
// insert or bad index: result is staged, then loaded into the output register once it is free
// query: the left-value scan moves one cell per cycle, then the result is staged and output
// one request at a time: in_stall_o holds off new requests until the result is loaded out
// reset: all directory slots clear to zero, active_size returns to 256
`default_nettype none

module chunk_id_directory
  import cid_pkg::*;
#(
  parameter int unsigned DEPTH = 256
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            cfg_we_i,
  input  wire logic [SzW-1:0]  cfg_wdata_i,
  input  wire logic            in_valid_i,
  output      logic            in_stall_o,
  input  wire logic            operation_i,
  input  wire logic [IdW-1:0]  slot_index_i,
  input  wire logic [ChW-1:0]  new_chunk_id_i,
  output      logic            out_valid_o,
  input  wire logic            out_stall_i,
  output      logic [AnsW-1:0] computed_chunk_id_o,
  output      logic            status_o
);

  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam int unsigned CapC = (DEPTH < 511) ? DEPTH : 511;

  cid_state_e      state_q, state_d;
  logic [SzW-1:0]  active_q;
  logic [SzW-1:0]  eff_size;
  logic [IdW-1:0]  target_q, target_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [AnsW-1:0] res_id_q, res_id_d;
  logic            res_st_q, res_st_d;
  logic            out_valid_q, out_valid_d;
  logic [AnsW-1:0] out_id_q, out_id_d;
  logic            out_st_q, out_st_d;
  logic            in_acc, out_free, bad;
  cid_bcast_t      bc;
  logic [ChW-1:0]  car [DEPTH];

  assign eff_size   = (active_q < SzW'(CapC)) ? active_q : SzW'(CapC);
  assign in_stall_o = state_q != S_IDLE;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign bad        = {1'b0, slot_index_i} >= eff_size;

  always_comb begin
    state_d     = state_q;
    target_d    = target_q;
    cnt_d       = cnt_q;
    res_id_d    = res_id_q;
    res_st_d    = res_st_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_id_d    = out_id_q;
    out_st_d    = out_st_q;

    bc.upd    = 1'b0;
    bc.idx    = slot_index_i;
    bc.id     = new_chunk_id_i;
    bc.size   = eff_size;
    bc.target = target_q;

    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          if (bad) begin
            res_id_d = '0;
            res_st_d = ST_BAD;
            state_d  = S_DONE;
          end else if (operation_i == OP_QUERY) begin
            target_d = slot_index_i;
            cnt_d    = '0;
            state_d  = S_SCAN;
          end else begin
            bc.upd   = 1'b1;
            res_id_d = '0;
            res_st_d = ST_OK;
            state_d  = S_DONE;
          end
        end
      end
      S_SCAN: begin
        cnt_d = cnt_q + CntW'(1);
        if (cnt_q == CntW'(DEPTH)) begin
          res_id_d = {1'b0, car[DEPTH-1]} + AnsW'(1);
          res_st_d = ST_OK;
          state_d  = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_id_d    = res_id_q;
          out_st_d    = res_st_q;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      active_q    <= SzW'(256);
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      cnt_q       <= cnt_d;
      if (cfg_we_i) begin
        active_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    target_q <= target_d;
    res_id_q <= res_id_d;
    res_st_q <= res_st_d;
    out_id_q <= out_id_d;
    out_st_q <= out_st_d;
  end

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    if (g == 0) begin : g_first
      cid_cell #(.POS(g)) u_cell (
        .clk_i (clk_i),
        .rst_ni(rst_ni),
        .bc_i  (bc),
        .car_i ('0),
        .car_o (car[g])
      );
    end else begin : g_rest
      cid_cell #(.POS(g)) u_cell (
        .clk_i (clk_i),
        .rst_ni(rst_ni),
        .bc_i  (bc),
        .car_i (car[g-1]),
        .car_o (car[g])
      );
    end
  end

  assign out_valid_o         = out_valid_q;
  assign computed_chunk_id_o = out_id_q;
  assign status_o            = out_st_q;

  a_scan_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN && cnt_q != CntW'(DEPTH))
      |=> (state_q == S_SCAN && cnt_q == $past(cnt_q) + CntW'(1)))
    else $error("scan counter did not advance");

  a_query_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && operation_i == OP_QUERY && !bad)
      |=> (state_q == S_SCAN && cnt_q == '0))
    else $error("query did not start a scan");

  a_bad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o == ST_BAD) |-> (computed_chunk_id_o == '0))
    else $error("bad index beat carries a nonzero id");

  a_done_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE && out_free) |=> (out_valid_q && state_q == S_IDLE))
    else $error("staged result not moved to output");

endmodule

`default_nettype wire
